// ===== rtl/core/nht_pkg.sv =====
// ----------------------------------------------------------------------------
// Nibble handshake transmitter package
// Shared types and constants for the front stage, the item queue and the
// handshake engine.
// ----------------------------------------------------------------------------
package nht_pkg;

  localparam int BYTE_W      = 8;
  localparam int NIB_W       = 4;
  localparam int PORT_W      = 5;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Bit 4 of the port is the data-available flag.
  localparam int FLAG_DAV_BIT = 4;

  localparam logic [PORT_W-1:0] PORT_IDLE = '0;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_LO_WAIT0   = 3'd1,
    PH_LO_PRESENT = 3'd2,
    PH_LO_WAIT1   = 3'd3,
    PH_HI_WAIT0   = 3'd4,
    PH_HI_PRESENT = 3'd5,
    PH_HI_WAIT1   = 3'd6
  } phase_t;

  // One decoded tick as it travels through the queue.
  typedef struct packed {
    logic              busy;
    logic [BYTE_W-1:0] data;
    logic              offer;
  } tick_t;

  // Handshake between the queue and the handshake engine.
  typedef struct packed {
    logic  valid;
    tick_t tick;
  } q_head_t;

endpackage

// ===== rtl/core/nht_front.sv =====
// ----------------------------------------------------------------------------
// Nibble handshake transmitter front stage
// Accepts input items, unpacks them into tick records and holds one in a
// register until the queue takes it.
// ----------------------------------------------------------------------------
module nht_front import nht_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  output logic                  fe_valid,
  input  logic                  fe_ready,
  output tick_t                 fe_tick
);

  logic  vld;
  tick_t tick;
  tick_t tick_next;

  assign s_axis_tready = !vld || fe_ready;

  always_comb begin
    tick_next.offer = s_axis_tdata[0];
    tick_next.data  = s_axis_tdata[BYTE_W:1];
    tick_next.busy  = s_axis_tdata[BYTE_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (s_axis_tready) begin
      vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      tick <= tick_next;
    end
  end

  assign fe_valid = vld;
  assign fe_tick  = tick;

endmodule

// ===== rtl/core/nht_queue.sv =====
// ----------------------------------------------------------------------------
// Nibble handshake transmitter item queue
// Short first-in first-out buffer that lets the front stage and the
// handshake engine stall independently.
// ----------------------------------------------------------------------------
module nht_queue import nht_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_valid,
  output logic    wr_ready,
  input  tick_t   wr_tick,
  output q_head_t head,
  input  logic    rd_pop
);

  tick_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr;
  logic [QUEUE_AW-1:0]  rd_ptr;
  logic [QUEUE_CW-1:0]  count;
  logic                 push;
  logic                 pop;

  assign wr_ready   = (count != QUEUE_CW'(QUEUE_DEPTH));
  assign push       = wr_valid && wr_ready;
  assign pop        = rd_pop && head.valid;
  assign head.valid = (count != '0);
  assign head.tick  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_tick;
    end
  end

endmodule

// ===== rtl/core/nht_engine.sv =====
// ----------------------------------------------------------------------------
// Nibble handshake transmitter handshake engine
// Steps the four-phase nibble handshake once per queued item and registers
// the port value, ready flag and done pulse for the output side.
// ----------------------------------------------------------------------------
module nht_engine import nht_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  q_head_t                head,
  output logic                   pop,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  phase_t              phase;
  phase_t              phase_next;
  logic [BYTE_W-1:0]   held_byte;
  logic [BYTE_W-1:0]   held_byte_next;
  logic [PORT_W-1:0]   port_reg;
  logic [PORT_W-1:0]   port_reg_next;
  logic                ready_next;
  logic                done_next;
  logic                out_vld;
  logic [PORT_W-1:0]   out_port;
  logic                out_ready;
  logic                out_done;
  logic [NIB_W-1:0]    lo_nib;
  logic [NIB_W-1:0]    hi_nib;
  logic [PORT_W-1:0]   dav;

  assign pop    = head.valid && (!out_vld || m_axis_tready);
  assign lo_nib = held_byte[NIB_W-1:0];
  assign hi_nib = held_byte[BYTE_W-1:NIB_W];
  assign dav    = PORT_W'(1) << FLAG_DAV_BIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      port_reg <= PORT_IDLE;
    end else if (pop) begin
      phase    <= phase_next;
      port_reg <= port_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      held_byte <= held_byte_next;
    end
  end

  always_comb begin
    phase_next     = phase;
    held_byte_next = held_byte;
    port_reg_next  = port_reg;
    ready_next     = 1'b0;
    done_next      = 1'b0;
    case (phase)
      PH_LO_WAIT0: begin
        if (!head.tick.busy) begin
          port_reg_next = PORT_W'(lo_nib);
          phase_next    = PH_LO_PRESENT;
        end
      end
      PH_LO_PRESENT: begin
        port_reg_next = PORT_W'(lo_nib) | dav;
        phase_next    = PH_LO_WAIT1;
      end
      PH_LO_WAIT1: begin
        if (head.tick.busy) begin
          port_reg_next = PORT_IDLE;
          phase_next    = PH_HI_WAIT0;
        end
      end
      PH_HI_WAIT0: begin
        if (!head.tick.busy) begin
          port_reg_next = PORT_W'(hi_nib);
          phase_next    = PH_HI_PRESENT;
        end
      end
      PH_HI_PRESENT: begin
        port_reg_next = PORT_W'(hi_nib) | dav;
        phase_next    = PH_HI_WAIT1;
      end
      PH_HI_WAIT1: begin
        if (head.tick.busy) begin
          port_reg_next = PORT_IDLE;
          done_next     = 1'b1;
          phase_next    = PH_IDLE;
        end
      end
      default: begin
        // Idle, and any code that should never appear, takes a new byte.
        ready_next = 1'b1;
        phase_next = PH_IDLE;
        if (head.tick.offer) begin
          held_byte_next = head.tick.data;
          port_reg_next  = PORT_IDLE;
          phase_next     = PH_LO_WAIT0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (!out_vld || m_axis_tready) begin
      out_vld <= head.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_port  <= port_reg_next;
      out_ready <= ready_next;
      out_done  <= done_next;
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {1'b0, out_done, out_ready, out_port};

  a_done_port_idle: assert property (@(posedge clk) disable iff (rst)
    out_vld && out_done |-> out_port == PORT_IDLE)
    else $error("done pulse with a driven port");

  a_ready_not_done: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> !(out_ready && out_done))
    else $error("ready and done in the same item");

  a_flag_phase: assert property (@(posedge clk) disable iff (rst)
    port_reg[FLAG_DAV_BIT] |-> (phase == PH_LO_WAIT1 || phase == PH_HI_WAIT1))
    else $error("data-available flag outside an acknowledge wait");

  a_present_step: assert property (@(posedge clk) disable iff (rst)
    pop && phase == PH_LO_PRESENT |=> phase == PH_LO_WAIT1 && port_reg[FLAG_DAV_BIT])
    else $error("low nibble presentation did not raise the flag");

endmodule

// ===== rtl/core/nibble_handshake_transmitter_core.sv =====
// ----------------------------------------------------------------------------
// Nibble handshake transmitter core
// Sends bytes as two nibbles with a four-phase handshake on a busy line.
// ----------------------------------------------------------------------------
// Each input item is one sampled tick of the cable and yields exactly one
// result item. The core takes one item per cycle when the output side keeps
// up; an accepted item passes from the front register through the queue
// into the output register, and the four-entry queue between the front
// stage and the handshake engine absorbs stalls on either side. The
// handshake state advances once per item, so waits on the busy line are
// counted in items, not in clock cycles.
// ----------------------------------------------------------------------------
module nibble_handshake_transmitter_core import nht_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [0] byte_valid, [8:1] data_byte, [9] busy_in, [15:10] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [4:0] port_out, [5] ready_res, [6] byte_done, [7] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic    fe_valid;
  logic    fe_ready;
  tick_t   fe_tick;
  q_head_t head;
  logic    pop;

  nht_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .fe_valid      (fe_valid),
    .fe_ready      (fe_ready),
    .fe_tick       (fe_tick)
  );

  nht_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fe_valid),
    .wr_ready (fe_ready),
    .wr_tick  (fe_tick),
    .head     (head),
    .rd_pop   (pop)
  );

  nht_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
